// File: src/cfl_pkg.sv
package cfl_pkg;

	// Fixed point format of every Q field.
	localparam int unsigned FRAC_BITS_DEF = 16;

	// Field and register widths.
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned GAMMA_W = 19;
	localparam int unsigned CFL_W   = 17;
	localparam int unsigned CELL_W  = 31;
	localparam int unsigned ITER_W  = 24;
	localparam int unsigned RES_W   = 31;
	localparam int unsigned CFG_W   = 31;
	localparam int unsigned IDX_W   = 2;

	// Width of the shared datapath and of its adder.
	localparam int unsigned WORK_W = 64;
	localparam int unsigned ADD_W  = 66;
	localparam int unsigned CNT_W  = 6;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_GAMMA = 2'd0;
	localparam logic [IDX_W-1:0] REG_CFL   = 2'd1;
	localparam logic [IDX_W-1:0] REG_CELL  = 2'd2;

	// Reset values of the registers.
	localparam logic [GAMMA_W-1:0] GAMMA_RST = 19'd91750;
	localparam logic [CFL_W-1:0]   CFL_RST   = 17'd58982;
	localparam logic [CELL_W-1:0]  CELL_RST  = 31'd655;

	// Start-up boost of the reported maximum.
	localparam logic [ITER_W-1:0] BOOST_ITERS = 24'd10;

	// Status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_RHO  = 2'd1;
	localparam logic [1:0] STAT_PRES = 2'd2;
	localparam logic [1:0] STAT_ZERO = 2'd3;

	localparam logic [RES_W-1:0] SAT31 = {RES_W{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULX,
		ST_MULY,
		ST_SQRTM,
		ST_DIVF,
		ST_DIVK,
		ST_ESUB,
		ST_MULP,
		ST_MULG,
		ST_DIVC,
		ST_SQRTS,
		ST_SUM,
		ST_FIN,
		ST_MULD,
		ST_DIVD,
		ST_OUT
	} state_t;

	// Clamp an unsigned word to the largest 31-bit value.
	function automatic logic [RES_W-1:0] sat31(input logic [WORK_W-1:0] v);
		logic [RES_W-1:0] r;
		r = (v[WORK_W-1:RES_W] != '0) ? SAT31 : v[RES_W-1:0];
		return r;
	endfunction

endpackage

// File: src/cfl_time_step_from_wave_speed.sv
// CFL time-step unit for a two-dimensional ideal-gas Euler solver. Each input beat carries one
// interior cell (density, two momenta, total energy, all signed fixed point with FRAC_BITS
// fraction bits). The unit forms the cell's flow speed plus sound speed and keeps the frame
// maximum; on the beat marked last_cell it delivers one output beat with that maximum (tripled
// while iteration_number is below ten), the time step cfl_number*min_cell_size/maximum and a
// status code, then clears the frame. All arithmetic runs through one shared 66-bit
// add/subtract unit under a sequencer: multiplies take one multiplier bit per cycle, divisions
// one quotient bit per cycle and square roots one root bit per cycle. A valid cell therefore
// occupies the unit for two squares, a root, three divisions, two short multiplies, a second
// root and the steps ESUB, SUM and FIN; a cell with a bad density goes straight to FIN, and
// the last cell of a frame adds the time-step multiply and division unless its status is not
// ok. in_ready is high only while the unit is idle. The result sits in an output register, so
// the next cell may be taken while a result beat still waits. Configuration writes are taken
// at any time and must only be issued while the unit is idle.
module cfl_time_step_from_wave_speed #(
	parameter int unsigned FRAC_BITS = cfl_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [cfl_pkg::DATA_W-1:0] density,
	input  logic signed [cfl_pkg::DATA_W-1:0] momentum_x,
	input  logic signed [cfl_pkg::DATA_W-1:0] momentum_y,
	input  logic signed [cfl_pkg::DATA_W-1:0] total_energy,
	input  logic                          last_cell,
	input  logic [cfl_pkg::ITER_W-1:0]    iteration_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cfl_pkg::RES_W-1:0]     max_wave_speed,
	output logic [cfl_pkg::RES_W-1:0]     time_step,
	output logic [1:0]                    status,
	input  logic                          cfg_write,
	input  logic [cfl_pkg::IDX_W-1:0]     cfg_index,
	input  logic [cfl_pkg::CFG_W-1:0]     cfg_data
);

	localparam int unsigned W = cfl_pkg::WORK_W;
	localparam int unsigned A = cfl_pkg::ADD_W;
	localparam logic [W-1:0] ONE_FX = W'(1) << FRAC_BITS;
	// At or above this c^2 the root would not fit, so the sound speed saturates.
	localparam logic [W-1:0] C2_LIM = W'(1) << (62 - FRAC_BITS);
	localparam logic [cfl_pkg::CNT_W-1:0] CNT_SQ   = 6'd31;
	localparam logic [cfl_pkg::CNT_W-1:0] CNT_SQRT = 6'd31;
	localparam logic [cfl_pkg::CNT_W-1:0] CNT_DIV  = 6'd63;
	localparam logic [cfl_pkg::CNT_W-1:0] CNT_ME   = 6'd30;
	localparam logic [cfl_pkg::CNT_W-1:0] CNT_MG   = 6'(cfl_pkg::GAMMA_W - 1);
	localparam logic [cfl_pkg::CNT_W-1:0] CNT_MC   = 6'(cfl_pkg::CFL_W - 1);

	// Configuration registers.
	logic [cfl_pkg::GAMMA_W-1:0] gamma_q;
	logic [cfl_pkg::CFL_W-1:0]   cfl_q;
	logic [cfl_pkg::CELL_W-1:0]  cell_q;

	// Frame state.
	logic [cfl_pkg::RES_W-1:0] max_q;
	logic [1:0]                fault_q;

	// Sequencer.
	cfl_pkg::state_t state_q, state_d;
	logic [cfl_pkg::CNT_W-1:0] cnt_q;
	logic last_it;

	// Latched cell and intermediate values.
	logic [cfl_pkg::RES_W-1:0]  rho_q;
	logic [cfl_pkg::DATA_W-1:0] ay_q;
	logic signed [cfl_pkg::DATA_W-1:0] energy_q;
	logic last_q;
	logic boost_q;
	logic [W-1:0] msq_q;
	logic [cfl_pkg::RES_W-1:0] flow_q;
	logic [cfl_pkg::RES_W-1:0] sound_q;
	logic [cfl_pkg::RES_W-1:0] amax_q;
	logic [cfl_pkg::RES_W-1:0] dt_q;
	logic [1:0] stat_q;

	// Shared working registers: accumulator or remainder, shifting operand, second operand.
	logic [W-1:0] acc_q;
	logic [W-1:0] wrk_q;
	logic [W-1:0] opd_q;

	// Output register.
	logic out_valid_q;
	logic [cfl_pkg::RES_W-1:0] out_max_q;
	logic [cfl_pkg::RES_W-1:0] out_dt_q;
	logic [1:0] out_stat_q;

	// Shared adder.
	logic [A-1:0] add_a, add_b, add_y;
	logic add_sub;
	logic add_neg;

	logic accept;
	logic rho_bad;
	logic [cfl_pkg::DATA_W-1:0] ax_in, ay_in;
	logic [cfl_pkg::GAMMA_W-1:0] gm1;
	logic [W-1:0] div_rem_sh, sqrt_rem_sh, sqrt_trial;
	logic [W-1:0] mul_acc_next, div_acc_next, div_q_next, sq_acc_next, sq_root_next;
	logic [cfl_pkg::RES_W-1:0] sum_sat, boost_sat, amax_new;
	logic [1:0] stat_new;
	logic out_load;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == cfl_pkg::ST_IDLE);
	assign last_it  = (cnt_q == '0);
	assign rho_bad  = density[cfl_pkg::DATA_W-1] || (density == '0);
	assign ax_in    = momentum_x[cfl_pkg::DATA_W-1] ? (~momentum_x + 1'b1) : momentum_x;
	assign ay_in    = momentum_y[cfl_pkg::DATA_W-1] ? (~momentum_y + 1'b1) : momentum_y;
	assign gm1      = (W'(gamma_q) > ONE_FX) ? cfl_pkg::GAMMA_W'(W'(gamma_q) - ONE_FX) : '0;

	// Operands of one restoring-division step and one square-root step.
	assign div_rem_sh  = {acc_q[W-2:0], wrk_q[W-1]};
	assign sqrt_rem_sh = {acc_q[W-3:0], wrk_q[W-1:W-2]};
	assign sqrt_trial  = {opd_q[W-3:0], 2'b01};

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			cfl_pkg::ST_MULX, cfl_pkg::ST_MULY, cfl_pkg::ST_MULP,
			cfl_pkg::ST_MULG, cfl_pkg::ST_MULD: begin
				add_a = A'(acc_q);
				add_b = A'(opd_q);
			end
			cfl_pkg::ST_SQRTM, cfl_pkg::ST_SQRTS: begin
				add_a   = A'(sqrt_rem_sh);
				add_b   = A'(sqrt_trial);
				add_sub = 1'b1;
			end
			cfl_pkg::ST_DIVF, cfl_pkg::ST_DIVK, cfl_pkg::ST_DIVC,
			cfl_pkg::ST_DIVD: begin
				add_a   = A'(div_rem_sh);
				add_b   = A'(opd_q);
				add_sub = 1'b1;
			end
			cfl_pkg::ST_ESUB: begin
				// Internal energy: total energy less the kinetic part held in wrk_q.
				add_a   = A'(signed'(energy_q));
				add_b   = A'(wrk_q);
				add_sub = 1'b1;
			end
			cfl_pkg::ST_SUM: begin
				add_a = A'(flow_q);
				add_b = A'(sound_q);
			end
			cfl_pkg::ST_FIN: begin
				add_a = A'(max_q);
				add_b = A'({max_q, 1'b0});
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	assign add_y   = add_a + (add_b ^ {A{add_sub}}) + A'(add_sub);
	assign add_neg = add_y[A-1];

	assign mul_acc_next = wrk_q[0] ? add_y[W-1:0] : acc_q;
	assign div_acc_next = add_neg ? div_rem_sh : add_y[W-1:0];
	assign div_q_next   = {wrk_q[W-2:0], ~add_neg};
	assign sq_acc_next  = add_neg ? sqrt_rem_sh : add_y[W-1:0];
	assign sq_root_next = {opd_q[W-2:0], ~add_neg};

	assign sum_sat   = cfl_pkg::sat31(add_y[W-1:0]);
	assign boost_sat = cfl_pkg::sat31(add_y[W-1:0]);
	assign amax_new  = boost_q ? boost_sat : max_q;
	always_comb begin
		if (fault_q != cfl_pkg::STAT_OK) begin
			stat_new = fault_q;
		end else if (amax_new == '0) begin
			stat_new = cfl_pkg::STAT_ZERO;
		end else begin
			stat_new = cfl_pkg::STAT_OK;
		end
	end

	assign out_load = (state_q == cfl_pkg::ST_OUT) && (!out_valid_q || out_ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfl_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = rho_bad ? cfl_pkg::ST_FIN : cfl_pkg::ST_MULX;
				end
			end
			cfl_pkg::ST_MULX:  if (last_it) state_d = cfl_pkg::ST_MULY;
			cfl_pkg::ST_MULY:  if (last_it) state_d = cfl_pkg::ST_SQRTM;
			cfl_pkg::ST_SQRTM: if (last_it) state_d = cfl_pkg::ST_DIVF;
			cfl_pkg::ST_DIVF:  if (last_it) state_d = cfl_pkg::ST_DIVK;
			cfl_pkg::ST_DIVK:  if (last_it) state_d = cfl_pkg::ST_ESUB;
			cfl_pkg::ST_ESUB: begin
				state_d = (add_neg && gm1 != '0) ? cfl_pkg::ST_FIN : cfl_pkg::ST_MULP;
			end
			cfl_pkg::ST_MULP:  if (last_it) state_d = cfl_pkg::ST_MULG;
			cfl_pkg::ST_MULG:  if (last_it) state_d = cfl_pkg::ST_DIVC;
			cfl_pkg::ST_DIVC: begin
				if (last_it) begin
					state_d = (div_q_next >= C2_LIM) ? cfl_pkg::ST_SUM : cfl_pkg::ST_SQRTS;
				end
			end
			cfl_pkg::ST_SQRTS: if (last_it) state_d = cfl_pkg::ST_SUM;
			cfl_pkg::ST_SUM:   state_d = cfl_pkg::ST_FIN;
			cfl_pkg::ST_FIN: begin
				if (!last_q) begin
					state_d = cfl_pkg::ST_IDLE;
				end else if (stat_new != cfl_pkg::STAT_OK) begin
					state_d = cfl_pkg::ST_OUT;
				end else begin
					state_d = cfl_pkg::ST_MULD;
				end
			end
			cfl_pkg::ST_MULD:  if (last_it) state_d = cfl_pkg::ST_DIVD;
			cfl_pkg::ST_DIVD:  if (last_it) state_d = cfl_pkg::ST_OUT;
			cfl_pkg::ST_OUT:   if (out_load) state_d = cfl_pkg::ST_IDLE;
			default:           state_d = cfl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= cfl_pkg::GAMMA_RST;
			cfl_q   <= cfl_pkg::CFL_RST;
			cell_q  <= cfl_pkg::CELL_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cfl_pkg::REG_GAMMA: gamma_q <= cfg_data[cfl_pkg::GAMMA_W-1:0];
				cfl_pkg::REG_CFL:   cfl_q   <= cfg_data[cfl_pkg::CFL_W-1:0];
				cfl_pkg::REG_CELL:  cell_q  <= cfg_data[cfl_pkg::CELL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Frame maximum and first fault; both are cleared once the frame's result is formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			fault_q <= cfl_pkg::STAT_OK;
		end else begin
			if (accept && rho_bad && fault_q == cfl_pkg::STAT_OK) begin
				fault_q <= cfl_pkg::STAT_RHO;
			end
			if (state_q == cfl_pkg::ST_ESUB && add_neg && gm1 != '0
					&& fault_q == cfl_pkg::STAT_OK) begin
				fault_q <= cfl_pkg::STAT_PRES;
			end
			if (state_q == cfl_pkg::ST_SUM && sum_sat > max_q) begin
				max_q <= sum_sat;
			end
			if (state_q == cfl_pkg::ST_FIN && last_q) begin
				max_q   <= '0;
				fault_q <= cfl_pkg::STAT_OK;
			end
		end
	end

	// Shared datapath. Each state runs one step of its operation and, on its last step,
	// loads the operands of the next one.
	always_ff @(posedge clk) begin
		if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
		unique case (state_q)
			cfl_pkg::ST_IDLE: begin
				rho_q    <= density[cfl_pkg::RES_W-1:0];
				ay_q     <= ay_in;
				energy_q <= total_energy;
				last_q   <= last_cell;
				boost_q  <= (iteration_number < cfl_pkg::BOOST_ITERS);
				acc_q    <= '0;
				opd_q    <= W'(ax_in);
				wrk_q    <= W'(ax_in);
				cnt_q    <= CNT_SQ;
			end
			cfl_pkg::ST_MULX, cfl_pkg::ST_MULY, cfl_pkg::ST_MULP,
			cfl_pkg::ST_MULG, cfl_pkg::ST_MULD: begin
				acc_q <= mul_acc_next;
				opd_q <= {opd_q[W-2:0], 1'b0};
				wrk_q <= {1'b0, wrk_q[W-1:1]};
				if (last_it) begin
					acc_q <= '0;
					cnt_q <= CNT_DIV;
					unique case (state_q)
						cfl_pkg::ST_MULX: begin
							// The y square accumulates on top of the x square.
							acc_q <= mul_acc_next;
							opd_q <= W'(ay_q);
							wrk_q <= W'(ay_q);
							cnt_q <= CNT_SQ;
						end
						cfl_pkg::ST_MULY: begin
							msq_q <= mul_acc_next;
							wrk_q <= mul_acc_next;
							opd_q <= '0;
							cnt_q <= CNT_SQRT;
						end
						cfl_pkg::ST_MULP: begin
							opd_q <= mul_acc_next >> FRAC_BITS;
							wrk_q <= W'(gamma_q);
							cnt_q <= CNT_MG;
						end
						cfl_pkg::ST_MULG: begin
							wrk_q <= mul_acc_next;
							opd_q <= W'(rho_q);
						end
						default: begin
							wrk_q <= mul_acc_next;
							opd_q <= W'(amax_q);
						end
					endcase
				end
			end
			cfl_pkg::ST_SQRTM, cfl_pkg::ST_SQRTS: begin
				acc_q <= sq_acc_next;
				opd_q <= sq_root_next;
				wrk_q <= {wrk_q[W-3:0], 2'b00};
				if (last_it) begin
					if (state_q == cfl_pkg::ST_SQRTM) begin
						acc_q <= '0;
						wrk_q <= sq_root_next << FRAC_BITS;
						opd_q <= W'(rho_q);
						cnt_q <= CNT_DIV;
					end else begin
						sound_q <= cfl_pkg::sat31(sq_root_next);
					end
				end
			end
			cfl_pkg::ST_DIVF, cfl_pkg::ST_DIVK, cfl_pkg::ST_DIVC,
			cfl_pkg::ST_DIVD: begin
				acc_q <= div_acc_next;
				wrk_q <= div_q_next;
				if (last_it) begin
					unique case (state_q)
						cfl_pkg::ST_DIVF: begin
							flow_q <= cfl_pkg::sat31(div_q_next);
							acc_q  <= '0;
							wrk_q  <= msq_q;
							opd_q  <= W'({rho_q, 1'b0});
							cnt_q  <= CNT_DIV;
						end
						cfl_pkg::ST_DIVK: begin
							// Quotient stays in wrk_q as the kinetic energy.
						end
						cfl_pkg::ST_DIVC: begin
							sound_q <= cfl_pkg::SAT31;
							acc_q   <= '0;
							opd_q   <= '0;
							wrk_q   <= div_q_next << FRAC_BITS;
							cnt_q   <= CNT_SQRT;
						end
						default: begin
							dt_q <= cfl_pkg::sat31(div_q_next);
						end
					endcase
				end
			end
			cfl_pkg::ST_ESUB: begin
				// A negative internal energy counts as zero when gamma is at or below one.
				acc_q <= '0;
				opd_q <= W'(gm1);
				wrk_q <= add_neg ? '0 : add_y[W-1:0];
				cnt_q <= CNT_ME;
			end
			cfl_pkg::ST_FIN: begin
				amax_q <= amax_new;
				stat_q <= stat_new;
				dt_q   <= cfl_pkg::SAT31;
				acc_q  <= '0;
				opd_q  <= W'(cell_q);
				wrk_q  <= W'(cfl_q);
				cnt_q  <= CNT_MC;
			end
			default: begin
			end
		endcase
	end

	// Output register: holds a finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_max_q  <= amax_q;
			out_dt_q   <= dt_q;
			out_stat_q <= stat_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign max_wave_speed = out_max_q;
	assign time_step      = out_dt_q;
	assign status         = out_stat_q;

	// A fault or a zero maximum always saturates the time step.
	a_fault_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stat_q != cfl_pkg::STAT_OK |-> out_dt_q == cfl_pkg::SAT31)
		else $error("faulted result without saturated time step");

	// A clean result has a nonzero maximum.
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stat_q == cfl_pkg::STAT_OK |-> out_max_q != '0)
		else $error("ok status with zero maximum");

	// An accepted cell always starts work.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != cfl_pkg::ST_IDLE)
		else $error("accepted cell left the sequencer idle");

	// A new result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || out_ready)
		else $error("result overwritten");

endmodule
